/* sv/uafl_pkg.sv */
// Package for the UTF-8 accent folding block: character constants, state type,
// and the fixed accent table. No dependencies.
package uafl_pkg;

  localparam logic [7:0] LeadC3    = 8'hc3;
  localparam logic [6:0] ChSpace   = 7'h20;
  localparam logic [6:0] ChA       = 7'h61;
  localparam logic [6:0] ChC       = 7'h63;
  localparam logic [6:0] ChD       = 7'h64;
  localparam logic [6:0] ChE       = 7'h65;
  localparam logic [6:0] ChI       = 7'h69;
  localparam logic [6:0] ChN       = 7'h6e;
  localparam logic [6:0] ChO       = 7'h6f;
  localparam logic [6:0] ChU       = 7'h75;
  localparam logic [6:0] ChY       = 7'h79;
  localparam logic [6:0] CaseBit   = 7'h20;

  typedef struct packed {
    logic [1:0] bytes_left;
    logic       lead_is_c3;
  } fold_state_t;

  function automatic logic [6:0] accent_lookup(input logic [5:0] idx);
    logic [6:0] ch;
    case (idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5,
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37:         ch = ChA;
      6'd7, 6'd39:                                      ch = ChC;
      6'd8, 6'd9, 6'd10, 6'd11, 6'd40, 6'd41, 6'd42, 6'd43: ch = ChE;
      6'd12, 6'd13, 6'd14, 6'd15, 6'd44, 6'd45, 6'd46, 6'd47: ch = ChI;
      6'd16:                                            ch = ChD;
      6'd17, 6'd49:                                     ch = ChN;
      6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
      6'd48, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54:         ch = ChO;
      6'd25, 6'd26, 6'd27, 6'd28, 6'd57, 6'd58, 6'd59, 6'd60: ch = ChU;
      6'd29, 6'd61, 6'd63:                              ch = ChY;
      default:                                          ch = ChSpace;
    endcase
    return ch;
  endfunction

endpackage

/* sv/utf8_accent_folding_lowercase_top.sv */
// Top level of the UTF-8 accent folding block: input register, fold logic,
// and result register. Depends on uafl_pkg and uafl_fold.
//
// Accepts one UTF-8 byte per cycle unless in_stall_o is high, and gives one
// lower-case ASCII character on the last byte of each source character; a zero
// byte ends a string and gives nothing. Throughput is one byte per cycle when
// no stall holds it. A byte passes through the input register, then the
// result register. in_stall_o rises only when both registers hold unaccepted
// data while out_stall_i is high.
module utf8_accent_folding_lowercase_top import uafl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_char_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  logic [6:0]  out_char_q;
  fold_state_t state_q, state_d;
  logic        s1_ready, s2_ready;
  logic        res_valid;
  logic [6:0]  res_char;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  uafl_fold u_fold (
    .byte_i      (s1_byte_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_char_o  (res_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q && res_valid;
        if (s1_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_byte_q <= in_byte_i;
    end
    if (s2_ready && s1_valid_q) begin
      out_char_q <= res_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;

endmodule

/* sv/uafl_fold.sv */
// Per-byte folding logic: decodes lead length, tracks the pending character,
// and forms the folded ASCII result. Depends on uafl_pkg.
module uafl_fold import uafl_pkg::*; (
  input  logic [7:0]  byte_i,
  input  fold_state_t state_i,
  output fold_state_t state_o,
  output logic        res_valid_o,
  output logic [6:0]  res_char_o
);

  logic [1:0] lead_extra;
  logic [6:0] single_char;
  logic [1:0] left_dec;

  always_comb begin
    case (byte_i[7:4])
      4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5,
      4'h6, 4'h7, 4'h8, 4'h9, 4'ha, 4'hb: lead_extra = 2'd0;
      4'hc, 4'hd:                         lead_extra = 2'd1;
      4'he:                               lead_extra = 2'd2;
      default:                            lead_extra = 2'd3;
    endcase
  end

  always_comb begin
    if ((byte_i >= 8'h30 && byte_i <= 8'h39) || (byte_i >= 8'h61 && byte_i <= 8'h7a)) begin
      single_char = byte_i[6:0];
    end else if (byte_i >= 8'h41 && byte_i <= 8'h5a) begin
      single_char = byte_i[6:0] | CaseBit;
    end else begin
      single_char = ChSpace;
    end
  end

  assign left_dec = state_i.bytes_left - 2'd1;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_char_o  = ChSpace;
    if (byte_i == 8'h00) begin
      state_o = '0;
    end else if (state_i.bytes_left != 2'd0) begin
      state_o.bytes_left = left_dec;
      if (left_dec == 2'd0) begin
        res_valid_o        = 1'b1;
        res_char_o         = state_i.lead_is_c3 ? accent_lookup(byte_i[5:0]) : ChSpace;
        state_o.lead_is_c3 = 1'b0;
      end
    end else if (lead_extra == 2'd0) begin
      res_valid_o = 1'b1;
      res_char_o  = single_char;
    end else begin
      state_o.bytes_left = lead_extra;
      state_o.lead_is_c3 = (byte_i == LeadC3);
    end
  end

endmodule

/* test/uafl_fold_monitor.sv */
// Transfer monitor for the UTF-8 accent folding block: predicts each folded
// character from the accepted input bytes and compares it with the result
// channel. Depends on uafl_pkg for the lead byte and character constants.
module uafl_fold_monitor import uafl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [6:0] out_char_i,
  output int         mismatches_o,
  output int         owed_o
);

  localparam logic [511:0] AccentText =
    "aaaaaa ceeeeiiiidnooooo  uuuuy  aaaaaa ceeeeiiiionooooo  uuuuy y";

  fold_state_t pend = '0;
  logic [6:0]  folded_q [$];
  int          bad = 0;

  function automatic int char_len(input logic [7:0] b);
    int ones;
    ones = 0;
    while (ones < 8 && b[7 - ones]) ones++;
    if (ones == 0) return 1;
    if (ones > 4) return 4;
    return ones;
  endfunction

  function automatic logic [6:0] fold_ascii(input logic [7:0] b);
    if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z")) return b[6:0];
    if (b >= "A" && b <= "Z") return b[6:0] | CaseBit;
    return ChSpace;
  endfunction

  function automatic logic [6:0] fold_accent(input logic [5:0] idx);
    logic [7:0] c;
    c = AccentText[(63 - int'(idx)) * 8 +: 8];
    return c[6:0];
  endfunction

  always @(posedge clk_i) begin
    int         len;
    logic [6:0] want;
    if (!rst_ni) begin
      pend = '0;
      folded_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (folded_q.size() == 0) begin
          $display("%0t: out_char expected none, got %h", $time, out_char_i);
          bad++;
        end else begin
          want = folded_q.pop_front();
          if (out_char_i !== want) begin
            $display("%0t: out_char expected %h, got %h", $time, want, out_char_i);
            bad++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_byte_i == 8'h00) begin
          pend = '0;
        end else if (pend.bytes_left != 2'd0) begin
          pend.bytes_left = pend.bytes_left - 2'd1;
          if (pend.bytes_left == 2'd0) begin
            folded_q.push_back(pend.lead_is_c3 ? fold_accent(in_byte_i[5:0]) : ChSpace);
            pend.lead_is_c3 = 1'b0;
          end
        end else begin
          len = char_len(in_byte_i);
          if (len == 1) begin
            folded_q.push_back(fold_ascii(in_byte_i));
          end else begin
            pend.bytes_left = 2'(len - 1);
            pend.lead_is_c3 = (in_byte_i == LeadC3) && (len == 2);
          end
        end
      end
    end
    mismatches_o <= bad;
    owed_o <= folded_q.size();
  end

endmodule

/* test/utf8_accent_folding_lowercase_top_test.sv */
// Testbench top for the UTF-8 accent folding block: drives byte streams with
// random gaps and stalls and gives the verdict. Depends on uafl_pkg,
// utf8_accent_folding_lowercase_top and uafl_fold_monitor.
module utf8_accent_folding_lowercase_top_test;
  import uafl_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_char;
  int         mismatches;
  int         owed;
  bit         hold_on = 1'b0;
  int         sent = 0;
  int         in_calm = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf8_accent_folding_lowercase_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_char_o  (out_char)
  );

  uafl_fold_monitor mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_char_i   (out_char),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic feed(input logic [7:0] b);
    int gap;
    if (hold_on || in_calm > 0) begin
      gap = 0;
      if (in_calm > 0) in_calm--;
    end else if ($urandom_range(0, 24) == 0) begin
      in_calm = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic feed_cont(input int n);
    repeat (n) feed(8'($urandom_range(8'h80, 8'hbf)));
  endtask

  task automatic feed_char();
    int kind;
    kind = $urandom_range(0, 19);
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        feed(8'($urandom_range(1, 127)));
      end
      6, 7, 8: begin
        feed(LeadC3);
        feed_cont(1);
      end
      9: begin
        feed(LeadC3);
        feed(8'($urandom_range(0, 255)));
      end
      10: begin
        feed(8'($urandom_range(8'hc0, 8'hdf)));
        feed_cont(1);
      end
      11, 12: begin
        feed(8'($urandom_range(8'he0, 8'hef)));
        feed_cont(2);
      end
      13: begin
        feed(8'($urandom_range(8'hf0, 8'hf7)));
        feed_cont(3);
      end
      14: begin
        feed(8'($urandom_range(8'hf8, 8'hff)));
        repeat (3) feed(8'($urandom_range(0, 255)));
      end
      15: begin
        feed(8'($urandom_range(8'h80, 8'hbf)));
      end
      16: begin
        feed(8'h00);
      end
      17: begin
        feed(8'($urandom_range(8'hc0, 8'hff)));
        feed(8'h00);
      end
      default: begin
        feed(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    logic [7:0] opening [25] = '{
      8'h30, 8'h39, 8'h61, 8'h7a, 8'h41, 8'h5a, 8'h7f, 8'h01, 8'h80,
      8'hc3, 8'hbf, 8'hc3, 8'h00, 8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac,
      8'hff, 8'h41, 8'h42, 8'h43, 8'hf0, 8'h41, 8'h00
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (opening[i]) feed(opening[i]);
    while (sent < 425) feed_char();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int wait_n;
    int out_calm;
    int got;
    out_calm = 0;
    got = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (got == 40 || got == 150) begin
        wait_n = 80;
        hold_on = 1'b1;
      end else if (out_calm > 0) begin
        out_calm--;
        wait_n = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        out_calm = $urandom_range(8, 40);
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(0, 16);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      hold_on = 1'b0;
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

endmodule
